// File: rtl/core/nnup_pkg.sv
// shared types and constants for the nearest neighbor integer upscaler
package nnup_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] REG_SCALE    = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_IN_WIDTH = 1'b1;

  // item actions
  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_PULL    = 1'b1;

  // field widths
  localparam int unsigned ScaleW = 7;
  localparam int unsigned WidthW = 11;
  localparam int unsigned PixW   = 24;

  // input word
  typedef struct packed {
    logic       action;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       block_end;
    logic       phase_error;
  } out_word_t;

  // control carried alongside the line buffer read
  typedef struct packed {
    logic       err;
    logic       row_end;
    logic [1:0] pad;
    logic       block_end;
  } nnup_ctrl_t;

endpackage

// File: rtl/core/nearest_neighbor_integer_upscaler.sv
// nearest neighbor integer upscaler: line buffer, repeat counters and output stage
//
// Capture words (action 0) fill a line buffer with one row of in_width pixels and
// give no result; once the row is full, each pull word (action 1) returns the next
// output pixel, each pixel repeated scale times across and the row repeated scale
// times down, with row_end and the 4-byte row padding on the last pixel of every
// output row and block_end on the last pixel of the block, after which the block
// takes a new row. A word in the wrong phase returns a phase_error word with all
// other fields zero. One word is taken every clock unless the input stalls; a
// result goes through the registered line buffer read and the output register.
// The input stalls only when both the read stage and the output register are full
// and the output is stalled. Configuration must be written only while idle; the
// block itself does not enforce it; out-of-range scale and width clamp when written.
module nearest_neighbor_integer_upscaler
  import nnup_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_SCALE = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WcW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ScW  = $clog2(MAX_SCALE + 1);

  // effective configuration, clamped when written
  logic [WcW-1:0] eff_w_q;
  logic [ScW-1:0] eff_s_q;
  logic [31:0]    cfg_wide;
  logic [WcW-1:0] cfg_w_d;
  logic [ScW-1:0] cfg_s_d;

  assign cfg_wide = {{(32-CfgDataW){1'b0}}, cfg_data_i};

  always_comb begin
    if (cfg_wide[WidthW-1:0] == '0) begin
      cfg_w_d = WcW'(1);
    end else if ({{(32-WidthW){1'b0}}, cfg_wide[WidthW-1:0]} > 32'(MAX_WIDTH)) begin
      cfg_w_d = WcW'(MAX_WIDTH);
    end else begin
      cfg_w_d = WcW'(cfg_wide[WidthW-1:0]);
    end
    if (cfg_wide[ScaleW-1:0] == '0) begin
      cfg_s_d = ScW'(1);
    end else if ({{(32-ScaleW){1'b0}}, cfg_wide[ScaleW-1:0]} > 32'(MAX_SCALE)) begin
      cfg_s_d = ScW'(MAX_SCALE);
    end else begin
      cfg_s_d = ScW'(cfg_wide[ScaleW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WcW'(1);
      eff_s_q <= ScW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE:    eff_s_q <= cfg_s_d;
        REG_IN_WIDTH: eff_w_q <= cfg_w_d;
        default: ;
      endcase
    end
  end

  // row padding: (-(3*w*s)) mod 4 equals (w*s) mod 4
  logic [3:0] pad_prod;
  logic [1:0] pad_bytes;
  assign pad_prod  = {2'b00, eff_w_q[1 % WcW]  & (WcW > 1), eff_w_q[0]}
                   * {2'b00, eff_s_q[1 % ScW] & (ScW > 1), eff_s_q[0]};
  assign pad_bytes = pad_prod[1:0];

  // handshake and stage control
  logic       s1_valid_q;
  nnup_ctrl_t s1_ctrl_q;
  logic       out_valid_q;
  out_word_t  out_q;
  logic       accept;
  logic       out_load;

  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_load   = s1_valid_q & (~out_valid_q | ~out_stall_i);

  // phase and counters
  logic           emitting_q, emitting_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ScW-1:0] across_q, across_d;
  logic [ScW-1:0] down_q, down_d;
  logic [WcW-1:0] col_inc;
  logic [ScW-1:0] across_inc;
  logic [ScW-1:0] down_inc;
  logic           wrong_phase;
  logic           is_pull;
  logic           mem_we;
  logic           mem_re;
  nnup_ctrl_t     ctrl_d;

  assign col_inc     = WcW'(col_q) + WcW'(1);
  assign across_inc  = across_q + ScW'(1);
  assign down_inc    = down_q + ScW'(1);
  assign wrong_phase = (in_word_i.action == ACT_PULL) != emitting_q;
  assign is_pull     = (in_word_i.action == ACT_PULL) & emitting_q;
  assign mem_we      = accept & ~wrong_phase & (in_word_i.action == ACT_CAPTURE);
  assign mem_re      = accept & is_pull;

  // next counter values and result flags
  always_comb begin
    emitting_d = emitting_q;
    col_d      = col_q;
    across_d   = across_q;
    down_d     = down_q;
    ctrl_d     = '0;
    ctrl_d.err = wrong_phase;
    if (!wrong_phase) begin
      if (in_word_i.action == ACT_CAPTURE) begin
        if (col_inc >= eff_w_q) begin
          col_d      = '0;
          across_d   = '0;
          down_d     = '0;
          emitting_d = 1'b1;
        end else begin
          col_d = col_inc[ColW-1:0];
        end
      end else begin
        if (across_inc >= eff_s_q) begin
          across_d = '0;
          if (col_inc >= eff_w_q) begin
            col_d          = '0;
            ctrl_d.row_end = 1'b1;
            ctrl_d.pad     = pad_bytes;
            if (down_inc >= eff_s_q) begin
              down_d           = '0;
              ctrl_d.block_end = 1'b1;
              emitting_d       = 1'b0;
            end else begin
              down_d = down_inc;
            end
          end else begin
            col_d = col_inc[ColW-1:0];
          end
        end else begin
          across_d = across_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitting_q <= 1'b0;
      col_q      <= '0;
      across_q   <= '0;
      down_q     <= '0;
    end else if (accept) begin
      emitting_q <= emitting_d;
      col_q      <= col_d;
      across_q   <= across_d;
      down_q     <= down_d;
    end
  end

  // line buffer, registered read
  logic [PixW-1:0] line_mem [MAX_WIDTH];
  logic [PixW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_q] <= {in_word_i.red, in_word_i.green, in_word_i.blue};
    end
    if (mem_re) begin
      rd_q <= line_mem[col_q];
    end
  end

  // read stage valid and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && (wrong_phase || is_pull)) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (wrong_phase || is_pull)) begin
      s1_ctrl_q <= ctrl_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_blue    <= s1_ctrl_q.err ? 8'h00 : rd_q[7:0];
      out_q.out_green   <= s1_ctrl_q.err ? 8'h00 : rd_q[15:8];
      out_q.out_red     <= s1_ctrl_q.err ? 8'h00 : rd_q[23:16];
      out_q.row_end     <= s1_ctrl_q.row_end;
      out_q.pad_bytes   <= s1_ctrl_q.pad;
      out_q.block_end   <= s1_ctrl_q.block_end;
      out_q.phase_error <= s1_ctrl_q.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the nearest neighbor integer upscaler
module testbench;
  import nnup_pkg::*;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxScale   = 100;
  localparam int unsigned PipeLat    = 2;
  localparam int unsigned StuckLimit = 3000;
  localparam int unsigned RandWords  = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_word_o;

  nearest_neighbor_integer_upscaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // predictor state, mirrors the block
  logic [PixW-1:0]     row_buf [MaxWidth];
  logic                in_output;
  int unsigned         buf_col;
  int unsigned         across_cnt;
  int unsigned         down_cnt;
  logic [ScaleW-1:0]   scale_reg;
  logic [WidthW-1:0]   width_reg;

  // expected output pixels, oldest first
  out_word_t           pending_px[$];
  out_word_t           exp_w;

  // run bookkeeping
  int unsigned         words_in;
  int unsigned         results_seen;
  int unsigned         phase_errs_seen;
  int unsigned         err_count;
  int unsigned         stuck_cycles;

  // receiver control
  bit                  no_idle;
  int unsigned         hold_req;
  int unsigned         hold_left;
  int unsigned         stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned width_eff();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  // expected result of one accepted word
  function automatic void upscale_predict(input in_word_t w);
    int unsigned wd;
    int unsigned sc;
    logic [PixW-1:0] pix;
    out_word_t r;
    wd = width_eff();
    sc = (scale_reg == 0) ? 1 : ((scale_reg > MaxScale) ? MaxScale : scale_reg);
    r = '0;
    if ((w.action == ACT_PULL) != in_output) begin
      // wrong phase: error word, state untouched
      r.phase_error = 1'b1;
      pending_px.push_back(r);
    end else if (w.action == ACT_CAPTURE) begin
      if (buf_col < MaxWidth) row_buf[buf_col] = {w.red, w.green, w.blue};
      buf_col++;
      if (buf_col >= wd) begin
        buf_col = 0;
        across_cnt = 0;
        down_cnt = 0;
        in_output = 1'b1;
      end
    end else begin
      pix = (buf_col < MaxWidth) ? row_buf[buf_col] : '0;
      across_cnt++;
      if (across_cnt >= sc) begin
        across_cnt = 0;
        buf_col++;
        if (buf_col >= wd) begin
          buf_col = 0;
          r.row_end = 1'b1;
          r.pad_bytes = 2'((4 - ((wd * sc * 3) % 4)) % 4);
          down_cnt++;
          if (down_cnt >= sc) begin
            down_cnt = 0;
            r.block_end = 1'b1;
            in_output = 1'b0;
          end
        end
      end
      r.out_blue  = pix[7:0];
      r.out_green = pix[15:8];
      r.out_red   = pix[23:16];
      pending_px.push_back(r);
    end
  endfunction

  // offer one word after a random gap, hold it until taken
  task automatic send_item(input logic act, input logic [PixW-1:0] px);
    int unsigned gap;
    in_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    w.action = act;
    w.blue   = px[7:0];
    w.green  = px[15:8];
    w.red    = px[23:16];
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_in++;
    upscale_predict(w);
  endtask

  // drop valid, let every result arrive and the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_SCALE) scale_reg = val[ScaleW-1:0];
    else width_reg = val;
  endtask

  task automatic set_config(input int unsigned sc, input int unsigned wd);
    wait_idle();
    write_reg(REG_SCALE, CfgDataW'(sc));
    write_reg(REG_IN_WIDTH, CfgDataW'(wd));
  endtask

  // one full row in and its whole block out, with some wrong-phase words mixed in
  task automatic run_block(input int unsigned noise_pct);
    while (!in_output) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(ACT_PULL, PixW'($urandom));
      send_item(ACT_CAPTURE, PixW'($urandom));
    end
    while (in_output) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(ACT_CAPTURE, PixW'($urandom));
      send_item(ACT_PULL, PixW'($urandom));
    end
  endtask

  // reset values, full-scale pixel, both wrong-phase cases
  task automatic test_default_regs();
    send_item(ACT_PULL, '0);
    send_item(ACT_CAPTURE, 24'hFFFFFF);
    send_item(ACT_CAPTURE, 24'h000000);
    send_item(ACT_PULL, 24'hFFFFFF);
  endtask

  // zero scale and width act as one
  task automatic test_range_clamps();
    set_config(0, 0);
    send_item(ACT_CAPTURE, 24'h000000);
    send_item(ACT_PULL, '0);
    send_item(ACT_CAPTURE, 24'hA5C35A);
    send_item(ACT_PULL, 24'hFFFFFF);
  endtask

  // row lengths that give padding counts of 2, 3 and 0
  task automatic test_row_padding();
    for (int unsigned wd = 2; wd <= 4; wd++) begin
      set_config(1, wd);
      run_block(0);
    end
  endtask

  // register writes between words of a phase
  task automatic test_live_reconfig();
    // scale drops to the across count
    set_config(5, 4);
    while (!in_output) send_item(ACT_CAPTURE, PixW'($urandom));
    repeat (7) send_item(ACT_PULL, '0);
    wait_idle();
    write_reg(REG_SCALE, CfgDataW'(2));
    while (in_output) send_item(ACT_PULL, '0);
    // width drops to the current column index
    set_config(2, 4);
    while (!in_output) send_item(ACT_CAPTURE, PixW'($urandom));
    repeat (5) send_item(ACT_PULL, '0);
    wait_idle();
    write_reg(REG_IN_WIDTH, CfgDataW'(2));
    while (in_output) send_item(ACT_PULL, '0);
    // width shrinks and then grows during capture
    set_config(1, 6);
    repeat (4) send_item(ACT_CAPTURE, PixW'($urandom));
    wait_idle();
    write_reg(REG_IN_WIDTH, CfgDataW'(3));
    run_block(0);
    set_config(1, 2);
    send_item(ACT_CAPTURE, PixW'($urandom));
    wait_idle();
    write_reg(REG_IN_WIDTH, CfgDataW'(5));
    run_block(0);
  endtask

  // top scale and the clamp above it, blocks cut short by a scale write
  task automatic test_max_scale();
    set_config(MaxScale, 1);
    send_item(ACT_CAPTURE, PixW'($urandom));
    repeat (150) send_item(ACT_PULL, '0);
    wait_idle();
    write_reg(REG_SCALE, CfgDataW'(2));
    while (in_output) send_item(ACT_PULL, '0);
    set_config(7'h7F, 1);
    send_item(ACT_CAPTURE, PixW'($urandom));
    repeat (120) send_item(ACT_PULL, '0);
    wait_idle();
    write_reg(REG_SCALE, CfgDataW'(1));
    while (in_output) send_item(ACT_PULL, '0);
  endtask

  // width written with every bit set, clamped to a full buffer, block cut short
  task automatic test_max_width();
    no_idle = 1'b1;
    set_config(1, 11'h7FF);
    while (!in_output) send_item(ACT_CAPTURE, PixW'($urandom));
    repeat (20) send_item(ACT_PULL, '0);
    wait_idle();
    write_reg(REG_IN_WIDTH, CfgDataW'(1));
    while (in_output) send_item(ACT_PULL, '0);
    no_idle = 1'b0;
  endtask

  // long output stall with the sender still pushing, then a drain pause
  task automatic test_backpressure();
    set_config(3, 4);
    while (!in_output) send_item(ACT_CAPTURE, PixW'($urandom));
    no_idle = 1'b1;
    hold_req = 300;
    repeat (30) send_item(ACT_PULL, PixW'($urandom));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    while (in_output) send_item(ACT_PULL, PixW'($urandom));
    no_idle = 1'b0;
  endtask

  // random settings and rows, some with mid-phase writes
  task automatic test_random_rows();
    int unsigned start;
    int unsigned pick;
    int unsigned sc;
    int unsigned wd;
    start = words_in;
    while (words_in - start < RandWords) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) sc = 0;
        else if (pick < 3) sc = $urandom_range(5, 8);
        else sc = $urandom_range(1, 4);
        pick = $urandom_range(0, 19);
        if (pick == 0) wd = 0;
        else if (pick < 3) wd = $urandom_range(13, 40);
        else wd = $urandom_range(1, 12);
        if (wd > 12 && sc > 2) sc = 2;
        if (sc > 4 && wd > 4) wd = 4;
        set_config(sc, wd);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // broken capture: width rewritten partway through a row
        repeat ($urandom_range(0, width_eff() - 1)) send_item(ACT_CAPTURE, PixW'($urandom));
        wait_idle();
        write_reg(REG_IN_WIDTH, CfgDataW'($urandom_range(1, 12)));
        run_block(5);
      end else if (pick == 1) begin
        // broken output: scale and a width no wider than before written mid-block
        while (!in_output) send_item(ACT_CAPTURE, PixW'($urandom));
        repeat ($urandom_range(1, 20)) if (in_output) send_item(ACT_PULL, PixW'($urandom));
        wait_idle();
        write_reg(REG_SCALE, CfgDataW'($urandom_range(1, 4)));
        write_reg(REG_IN_WIDTH, CfgDataW'($urandom_range(1, width_eff())));
        while (in_output) send_item(ACT_PULL, PixW'($urandom));
      end else begin
        run_block(5);
      end
    end
    no_idle = 1'b0;
  endtask

  // output side: check each result word, draw the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_px.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result word %h", out_word_o);
        end else begin
          exp_w = pending_px.pop_front();
          if (exp_w.phase_error) phase_errs_seen++;
          if (out_word_o.out_blue !== exp_w.out_blue ||
              out_word_o.out_green !== exp_w.out_green ||
              out_word_o.out_red !== exp_w.out_red ||
              out_word_o.row_end !== exp_w.row_end ||
              out_word_o.pad_bytes !== exp_w.pad_bytes ||
              out_word_o.block_end !== exp_w.block_end ||
              out_word_o.phase_error !== exp_w.phase_error) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch at %0t: exp b %h g %h r %h row %b pad %0d blk %b err %b",
                       $realtime, exp_w.out_blue, exp_w.out_green, exp_w.out_red,
                       exp_w.row_end, exp_w.pad_bytes, exp_w.block_end, exp_w.phase_error,
                       "\n    got b %h g %h r %h row %b pad %0d blk %b err %b",
                       out_word_o.out_blue, out_word_o.out_green, out_word_o.out_red,
                       out_word_o.row_end, out_word_o.pad_bytes, out_word_o.block_end,
                       out_word_o.phase_error);
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no word moved for %0d cycles", StuckLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_SCALE;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    in_output   = 1'b0;
    buf_col     = 0;
    across_cnt  = 0;
    down_cnt    = 0;
    scale_reg   = 1;
    width_reg   = 1;
    words_in    = 0;
    results_seen = 0;
    phase_errs_seen = 0;
    err_count   = 0;
    stuck_cycles = 0;
    no_idle     = 1'b0;
    hold_req    = 0;
    hold_left   = 0;
    stall_left  = 0;
    for (int i = 0; i < MaxWidth; i++) row_buf[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_regs();
    test_range_clamps();
    test_row_padding();
    test_live_reconfig();
    test_max_scale();
    test_max_width();
    test_backpressure();
    test_random_rows();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (pending_px.size() != 0) err_count++;
    $display("run: %0d words in, %0d result words checked, %0d of them phase errors",
             words_in, results_seen, phase_errs_seen);
    $display("covered scales 1 to 100 with clamps, rows 1 to 1024 pixels, mid-phase writes");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: nearest_neighbor_integer_upscaler.f
rtl/core/nnup_pkg.sv
rtl/core/nearest_neighbor_integer_upscaler.sv
verif/testbench.sv
